// File: src/sos_pkg.sv
// shared types, codes and constants of the sample order statistics block
package sos_pkg;

  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned SET_SIZE_W = 11;
  localparam int unsigned PM_W       = 10;
  localparam int unsigned NUM_LANES  = 4;

  localparam logic [PM_W-1:0] FIRST_PM_RESET  = 10'd950;
  localparam logic [PM_W-1:0] SECOND_PM_RESET = 10'd990;

  // ceil(x / 1000) via (x + 999) * ceil(2^40 / 1000) >> 40
  localparam int unsigned  RANK_BIAS   = 999;
  localparam int unsigned  RECIP_SHIFT = 40;
  localparam int unsigned  RECIP_W     = 31;
  localparam logic [30:0]  RECIP_MULT  = 31'd1099511628;

  // radix select lanes
  localparam int unsigned LANE_MED_LO = 0;
  localparam int unsigned LANE_MED_HI = 1;
  localparam int unsigned LANE_PCT1   = 2;
  localparam int unsigned LANE_PCT2   = 3;

  // register index as seen on paddr[2]
  localparam logic REG_FIRST_PM  = 1'b0;
  localparam logic REG_SECOND_PM = 1'b1;

  typedef struct packed {
    logic [31:0] sample_value;
    logic        is_last;
  } sample_t;

  typedef struct packed {
    logic [31:0]           minimum_value;
    logic [31:0]           mean_value;
    logic [31:0]           median_value;
    logic [31:0]           first_percentile;
    logic [31:0]           second_percentile;
    logic [31:0]           maximum_value;
    logic [SET_SIZE_W-1:0] set_size;
    logic                  overflow;
  } result_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL1,
    BK_MUL2,
    BK_INDEX,
    BK_SCAN,
    BK_FINISH
  } back_state_e;

endpackage

// File: src/sos_ram.sv
// generic single write port ram with registered read
module sos_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/sos_front.sv
// front part: takes samples, fills the store, keeps sum, min, max and overflow
module sos_front
  import sos_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  sample_t                        sample_i,
  output logic                           full_o,
  input  logic                           store_busy_i,
  output logic                           ram_we_o,
  output logic [$clog2(MAX_SAMPLES)-1:0] ram_waddr_o,
  output logic [SAMPLE_W-1:0]            ram_wdata_o,
  output logic                           job_valid_o,
  input  logic                           job_take_i,
  output logic [$clog2(MAX_SAMPLES+1)-1:0] job_count_o,
  output logic [SAMPLE_W+$clog2(MAX_SAMPLES+1)-1:0] job_sum_o,
  output logic [SAMPLE_W-1:0]            job_min_o,
  output logic [SAMPLE_W-1:0]            job_max_o,
  output logic                           job_ovf_o
);

  localparam int unsigned AW = $clog2(MAX_SAMPLES);
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SW = SAMPLE_W + CW;

  logic [CW-1:0]       count_q, count_d;
  logic [SW-1:0]       sum_q, sum_d;
  logic [SAMPLE_W-1:0] min_q, min_d, max_q, max_d;
  logic                ovf_q, ovf_d;
  logic                job_valid_q;
  logic [CW-1:0]       job_count_q;
  logic [SW-1:0]       job_sum_q;
  logic [SAMPLE_W-1:0] job_min_q, job_max_q;
  logic                job_ovf_q;
  logic                accept, room, store, first;

  assign full_o = job_valid_q | store_busy_i;
  assign accept = push_i & ~full_o;
  assign room   = (count_q != CW'(MAX_SAMPLES));
  assign store  = accept & room;
  assign first  = (count_q == '0);

  assign ram_we_o    = store;
  assign ram_waddr_o = count_q[AW-1:0];
  assign ram_wdata_o = sample_i.sample_value;

  always_comb begin
    count_d = store ? count_q + CW'(1) : count_q;
    sum_d   = store ? sum_q + SW'(sample_i.sample_value) : sum_q;
    min_d   = (store && (first || sample_i.sample_value < min_q)) ?
              sample_i.sample_value : min_q;
    max_d   = (store && (first || sample_i.sample_value > max_q)) ?
              sample_i.sample_value : max_q;
    ovf_d   = ovf_q | (accept & ~room);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      job_valid_q <= 1'b0;
    end else if (accept && sample_i.is_last) begin
      count_q     <= '0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      job_valid_q <= 1'b1;
    end else begin
      if (accept) begin
        count_q <= count_d;
        sum_q   <= sum_d;
        ovf_q   <= ovf_d;
      end
      if (job_take_i) begin
        job_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      min_q <= min_d;
      max_q <= max_d;
    end
    if (accept && sample_i.is_last) begin
      job_count_q <= count_d;
      job_sum_q   <= sum_d;
      job_min_q   <= min_d;
      job_max_q   <= max_d;
      job_ovf_q   <= ovf_d;
    end
  end

  assign job_valid_o = job_valid_q;
  assign job_count_o = job_count_q;
  assign job_sum_o   = job_sum_q;
  assign job_min_o   = job_min_q;
  assign job_max_o   = job_max_q;
  assign job_ovf_o   = job_ovf_q;

endmodule

// File: src/sos_back.sv
// back part: rank math, radix select over the store, mean divider, result register
module sos_back
  import sos_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           job_valid_i,
  output logic                           job_take_o,
  input  logic [$clog2(MAX_SAMPLES+1)-1:0] job_count_i,
  input  logic [SAMPLE_W+$clog2(MAX_SAMPLES+1)-1:0] job_sum_i,
  input  logic [SAMPLE_W-1:0]            job_min_i,
  input  logic [SAMPLE_W-1:0]            job_max_i,
  input  logic                           job_ovf_i,
  input  logic [PM_W-1:0]                first_pm_i,
  input  logic [PM_W-1:0]                second_pm_i,
  output logic [$clog2(MAX_SAMPLES)-1:0] ram_raddr_o,
  input  logic [SAMPLE_W-1:0]            ram_rdata_i,
  output logic                           store_busy_o,
  output result_t                        result_o,
  output logic                           empty_o,
  input  logic                           pop_i
);

  localparam int unsigned AW  = $clog2(MAX_SAMPLES);
  localparam int unsigned CW  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SW  = SAMPLE_W + CW;
  localparam int unsigned XW  = CW + PM_W + 1;
  localparam int unsigned PRW = XW + RECIP_W;
  localparam int unsigned RKW = CW + 1;
  localparam int unsigned DCW = $clog2(SW + 1);

  back_state_e state_q, state_d;

  logic [CW-1:0]       n_q;
  logic                ovf_q;
  logic [SAMPLE_W-1:0] min_q, max_q;
  logic [XW-1:0]       x_q [2];
  logic [RKW-1:0]      rank_q [2];
  logic [PRW-1:0]      prod [2];
  logic [CW-1:0]       idx [2];
  logic [RKW-1:0]      rank_m1 [2];

  logic [SAMPLE_W-1:0] prefix_q [NUM_LANES];
  logic [CW-1:0]       krem_q [NUM_LANES];
  logic [CW-1:0]       cnt_q [NUM_LANES];
  logic [CW-1:0]       cnt_full [NUM_LANES];
  logic                hit [NUM_LANES];
  logic [SAMPLE_W-1:0] himask_q, bitm_q;
  logic [CW-1:0]       addr_q;
  logic                rvalid_q, rlast_q;
  logic                issue, pass_end;

  logic [DCW-1:0]      div_cnt_q;
  logic [CW-1:0]       rem_q;
  logic [SW-1:0]       quo_q;
  logic [CW:0]         div_shift;
  logic                div_ge, div_done;

  logic                out_valid_q, out_write;
  result_t             out_q, out_d;
  logic [SAMPLE_W:0]   med_sum;

  // rank and index math
  always_comb begin
    prod[0] = PRW'(x_q[0]) * PRW'(RECIP_MULT);
    prod[1] = PRW'(x_q[1]) * PRW'(RECIP_MULT);
    for (int l = 0; l < 2; l++) begin
      rank_m1[l] = (rank_q[l] == '0) ? '0 : rank_q[l] - RKW'(1);
      idx[l]     = (rank_m1[l] >= {1'b0, n_q}) ? n_q - CW'(1) : rank_m1[l][CW-1:0];
    end
  end

  // radix select: one bit of every lane per pass over the store
  assign issue    = (state_q == BK_SCAN) && (addr_q != n_q);
  assign pass_end = rvalid_q && rlast_q;
  assign ram_raddr_o = addr_q[AW-1:0];

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      hit[l] = rvalid_q && (((ram_rdata_i ^ prefix_q[l]) & himask_q) == '0) &&
               ((ram_rdata_i & bitm_q) == '0);
      cnt_full[l] = cnt_q[l] + CW'(hit[l]);
    end
  end

  // restoring divider for the mean
  assign div_shift = {rem_q, quo_q[SW-1]};
  assign div_ge    = (div_shift >= {1'b0, n_q});
  assign div_done  = (div_cnt_q == '0);

  assign med_sum = (SAMPLE_W+1)'(prefix_q[LANE_MED_LO]) +
                   (SAMPLE_W+1)'(prefix_q[LANE_MED_HI]);

  always_comb begin
    out_d = '0;
    if (ovf_q) begin
      out_d.overflow = 1'b1;
    end else begin
      out_d.minimum_value     = min_q;
      out_d.mean_value        = quo_q[SAMPLE_W-1:0];
      out_d.median_value      = med_sum[SAMPLE_W:1];
      out_d.first_percentile  = prefix_q[LANE_PCT1];
      out_d.second_percentile = prefix_q[LANE_PCT2];
      out_d.maximum_value     = max_q;
      out_d.set_size          = SET_SIZE_W'(n_q);
    end
  end

  always_comb begin
    state_d    = state_q;
    job_take_o = 1'b0;
    out_write  = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          job_take_o = 1'b1;
          state_d    = job_ovf_i ? BK_FINISH : BK_MUL1;
        end
      end
      BK_MUL1:  state_d = BK_MUL2;
      BK_MUL2:  state_d = BK_INDEX;
      BK_INDEX: state_d = BK_SCAN;
      BK_SCAN: begin
        if (pass_end && bitm_q[0]) begin
          state_d = BK_FINISH;
        end
      end
      BK_FINISH: begin
        if (!out_valid_q && div_done) begin
          out_write = 1'b1;
          state_d   = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  assign store_busy_o = (state_q == BK_MUL1) || (state_q == BK_MUL2) ||
                        (state_q == BK_INDEX) || (state_q == BK_SCAN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      rvalid_q    <= 1'b0;
      div_cnt_q   <= '0;
    end else begin
      state_q  <= state_d;
      rvalid_q <= issue;
      if (out_write) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
      if (job_take_o) begin
        div_cnt_q <= DCW'(SW);
      end else if (!div_done) begin
        div_cnt_q <= div_cnt_q - DCW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_take_o) begin
      n_q   <= job_count_i;
      ovf_q <= job_ovf_i;
      min_q <= job_min_i;
      max_q <= job_max_i;
      rem_q <= '0;
      quo_q <= job_sum_i;
    end else if (!div_done) begin
      rem_q <= div_ge ? CW'(div_shift - {1'b0, n_q}) : div_shift[CW-1:0];
      quo_q <= {quo_q[SW-2:0], div_ge};
    end
    if (state_q == BK_MUL1) begin
      x_q[0] <= XW'(n_q) * XW'(first_pm_i) + XW'(RANK_BIAS);
      x_q[1] <= XW'(n_q) * XW'(second_pm_i) + XW'(RANK_BIAS);
    end
    if (state_q == BK_MUL2) begin
      rank_q[0] <= prod[0][RECIP_SHIFT +: RKW];
      rank_q[1] <= prod[1][RECIP_SHIFT +: RKW];
    end
    rlast_q <= issue && (addr_q == n_q - CW'(1));
    if (state_q == BK_INDEX) begin
      krem_q[LANE_MED_LO] <= (n_q - CW'(1)) >> 1;
      krem_q[LANE_MED_HI] <= n_q >> 1;
      krem_q[LANE_PCT1]   <= idx[0];
      krem_q[LANE_PCT2]   <= idx[1];
      for (int l = 0; l < NUM_LANES; l++) begin
        prefix_q[l] <= '0;
        cnt_q[l]    <= '0;
      end
      himask_q <= '0;
      bitm_q   <= {1'b1, {(SAMPLE_W-1){1'b0}}};
      addr_q   <= '0;
    end else if (state_q == BK_SCAN) begin
      if (issue) begin
        addr_q <= addr_q + CW'(1);
      end
      if (pass_end) begin
        for (int l = 0; l < NUM_LANES; l++) begin
          cnt_q[l] <= '0;
          if (krem_q[l] >= cnt_full[l]) begin
            prefix_q[l] <= prefix_q[l] | bitm_q;
            krem_q[l]   <= krem_q[l] - cnt_full[l];
          end
        end
        himask_q <= {1'b1, himask_q[SAMPLE_W-1:1]};
        bitm_q   <= bitm_q >> 1;
        addr_q   <= '0;
      end else begin
        for (int l = 0; l < NUM_LANES; l++) begin
          cnt_q[l] <= cnt_full[l];
        end
      end
    end
    if (out_write) begin
      out_q <= out_d;
    end
  end

  assign result_o = out_q;
  assign empty_o  = ~out_valid_q;

  a_job_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_IDLE && job_valid_i) |=> (state_q != BK_IDLE))
    else $error("pending job not taken by idle back end");

  a_read_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvalid_q |-> (state_q == BK_SCAN))
    else $error("store read data outside of scan");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == BK_FINISH && $past(div_done)))
    else $error("result written before finish or before divider done");

endmodule

// File: src/sample_order_statistics.sv
// top level of the sample order statistics block: config registers and part wiring
//
// Samples load one beat per cycle while full is low into a store of MAX_SAMPLES
// entries, while a running sum, minimum and maximum are kept. The beat with
// is_last closes the set; full then stays high while the back part works on the
// store: rank math in the multiply and index states, then 32 radix-select passes,
// each reading every stored sample once through the store's single read port.
// The floor mean comes from a bit-serial divider that runs alongside the passes
// (SAMPLE width plus count width steps). An overflowed set skips the passes and
// takes only the divider time. The result beat waits in an output register, so
// the next set can load while it is not yet popped. The percentile registers sit
// at byte addresses 0 and 4 and should only be written while the block is idle.
module sample_order_statistics
  import sos_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // sample side
  input  logic        push,
  output logic        full,
  input  sample_t     sample_i,
  // result side
  output logic        empty,
  input  logic        pop,
  output result_t     result_o,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = $clog2(MAX_SAMPLES);
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SW = SAMPLE_W + CW;

  // percentile registers
  logic [PM_W-1:0] first_pm_q, second_pm_q;
  logic            cfg_write;

  // store ports
  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;

  // handoff between front and back
  logic                job_valid, job_take, store_busy, job_ovf;
  logic [CW-1:0]       job_count;
  logic [SW-1:0]       job_sum;
  logic [SAMPLE_W-1:0] job_min, job_max;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_pm_q  <= FIRST_PM_RESET;
      second_pm_q <= SECOND_PM_RESET;
    end else if (cfg_write) begin
      // only paddr[2] picks the register
      unique case (paddr[2])
        REG_FIRST_PM:  first_pm_q  <= pwdata[PM_W-1:0];
        REG_SECOND_PM: second_pm_q <= pwdata[PM_W-1:0];
        default:       first_pm_q  <= first_pm_q;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_SECOND_PM) ? 32'(second_pm_q) : 32'(first_pm_q);

  // front fills the store and hands a closed set to the back
  sos_front #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .sample_i     (sample_i),
    .full_o       (full),
    .store_busy_i (store_busy),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .job_valid_o  (job_valid),
    .job_take_i   (job_take),
    .job_count_o  (job_count),
    .job_sum_o    (job_sum),
    .job_min_o    (job_min),
    .job_max_o    (job_max),
    .job_ovf_o    (job_ovf)
  );

  // sample store, written by the front, read by the back
  sos_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // back computes the order statistics and holds the result beat
  sos_back #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (job_valid),
    .job_take_o   (job_take),
    .job_count_i  (job_count),
    .job_sum_i    (job_sum),
    .job_min_i    (job_min),
    .job_max_i    (job_max),
    .job_ovf_i    (job_ovf),
    .first_pm_i   (first_pm_q),
    .second_pm_i  (second_pm_q),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .store_busy_o (store_busy),
    .result_o     (result_o),
    .empty_o      (empty),
    .pop_i        (pop)
  );

endmodule

// File: sim/tb.sv
// self-checking testbench of the sample order statistics block
module tb;
  import sos_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SET_CAP   = 1024;
  localparam int unsigned RUN_LIMIT = 3000000;
  localparam int unsigned DRAIN_CYC = 40000;
  localparam int unsigned IDLE_GAP  = 64;
  localparam int unsigned HOLD_CYC  = 6000;
  localparam logic [2:0]  ADDR_FIRST_PM  = {REG_FIRST_PM, 2'b00};
  localparam logic [2:0]  ADDR_SECOND_PM = {REG_SECOND_PM, 2'b00};

  // one row of the directed table: a beat and, where obvious, its result
  typedef struct {
    sample_t beat;
    bit      typed;
    result_t want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  sample_t     sample_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  result_t     result_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sample_order_statistics #(.MAX_SAMPLES(SET_CAP)) u_dut (
    .clk_i, .rst_ni, .push, .full, .sample_i, .empty, .pop, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state: percentile settings and the set being loaded
  logic [PM_W-1:0] pm_first  = FIRST_PM_RESET;
  logic [PM_W-1:0] pm_second = SECOND_PM_RESET;
  logic [31:0]     open_set[$];
  bit              open_ovf;
  result_t         stats_due[$];

  int unsigned cycle_cnt;
  int unsigned err_cnt;
  int unsigned beats_sent;
  int unsigned sets_closed;
  int unsigned ovf_sets;
  bit          long_hold;

  // nearest-rank index, saturated at the last sample
  function automatic int unsigned rank_pos(int unsigned n, logic [PM_W-1:0] pm);
    longint unsigned rank;
    longint unsigned pos;
    rank = (longint'(n) * pm + 999) / 1000;
    pos  = (rank == 0) ? 0 : rank - 1;
    if (pos >= n)
      pos = n - 1;
    return int'(pos);
  endfunction

  function automatic result_t set_stats();
    result_t         r;
    logic [31:0]     srt[$];
    longint unsigned total;
    int unsigned     n;
    r = '0;
    if (open_ovf) begin
      r.overflow = 1'b1;
      return r;
    end
    srt = open_set;
    srt.sort();
    n = srt.size();
    total = 0;
    foreach (srt[i])
      total += srt[i];
    r.minimum_value = srt[0];
    r.maximum_value = srt[n-1];
    r.mean_value    = 32'(total / n);
    if (n % 2 == 0)
      r.median_value = 32'(({1'b0, srt[n/2-1]} + {1'b0, srt[n/2]}) >> 1);
    else
      r.median_value = srt[n/2];
    r.first_percentile  = srt[rank_pos(n, pm_first)];
    r.second_percentile = srt[rank_pos(n, pm_second)];
    r.set_size = SET_SIZE_W'(n);
    return r;
  endfunction

  // offer one beat, hold it until accepted, then fold it into the predictor
  task automatic send_beat(sample_t b, bit typed = 0, result_t want = '0);
    push     <= 1'b1;
    sample_i <= b;
    do @(posedge clk_i); while (full);
    beats_sent++;
    if (open_set.size() < SET_CAP)
      open_set.push_back(b.sample_value);
    else
      open_ovf = 1'b1;
    if (b.is_last) begin
      stats_due.push_back(typed ? want : set_stats());
      sets_closed++;
      if (open_ovf)
        ovf_sets++;
      open_set.delete();
      open_ovf = 1'b0;
    end
  endtask

  // random gap on the sample side: mostly none, sometimes short, rarely long
  task automatic push_gap();
    int unsigned g;
    g = $urandom_range(0, 99);
    if (g < 60)
      return;
    push <= 1'b0;
    if (g < 97)
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    else
      repeat ($urandom_range(20, 120)) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_value(int unsigned kind);
    case (kind)
      0: return 32'($urandom_range(0, 15));
      1: return 32'hFFFF_FFFF - 32'($urandom_range(0, 7));
      default: return $urandom();
    endcase
  endfunction

  // random set of the given length, all in one value flavor
  task automatic send_set(int unsigned len);
    int unsigned kind;
    sample_t     b;
    kind = $urandom_range(0, 3);
    for (int unsigned i = 0; i < len; i++) begin
      b.sample_value = rand_value(kind);
      b.is_last      = (i == len - 1);
      send_beat(b);
      push_gap();
    end
    push <= 1'b0;
    @(posedge clk_i);
  endtask

  // registers are only touched with nothing outstanding
  task automatic write_pm(logic [2:0] addr, logic [31:0] val);
    while (stats_due.size() != 0)
      @(posedge clk_i);
    repeat (IDLE_GAP) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_FIRST_PM)
      pm_first = val[PM_W-1:0];
    else
      pm_second = val[PM_W-1:0];
  endtask

  task automatic set_pms(logic [31:0] first_pm, logic [31:0] second_pm);
    write_pm(ADDR_FIRST_PM, first_pm);
    write_pm(ADDR_SECOND_PM, second_pm);
  endtask

  // result side: pop mostly high, random short gaps, a rare long one,
  // and one long hold-off on request so the block backs up into full
  initial begin
    int unsigned g;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        pop <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk_i);
        long_hold = 1'b0;
      end else begin
        g = $urandom_range(0, 99);
        if (g < 70)
          pop <= 1'b1;
        else if (g < 98) begin
          pop <= 1'b0;
          repeat ($urandom_range(0, 3)) @(posedge clk_i);
        end else begin
          pop <= 1'b0;
          repeat ($urandom_range(30, 300)) @(posedge clk_i);
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
      err_cnt++;
    end
  endtask

  // compare each popped result beat with the oldest prediction
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && pop && !empty) begin
      if (stats_due.size() == 0) begin
        $display("%0t: result beat with none expected, got %h", $realtime, result_o);
        err_cnt++;
      end else begin
        want = stats_due.pop_front();
        check_field("minimum_value", want.minimum_value, result_o.minimum_value);
        check_field("mean_value", want.mean_value, result_o.mean_value);
        check_field("median_value", want.median_value, result_o.median_value);
        check_field("first_percentile", want.first_percentile,
                    result_o.first_percentile);
        check_field("second_percentile", want.second_percentile,
                    result_o.second_percentile);
        check_field("maximum_value", want.maximum_value, result_o.maximum_value);
        check_field("set_size", 32'(want.set_size), 32'(result_o.set_size));
        check_field("overflow", 32'(want.overflow), 32'(result_o.overflow));
      end
    end
  end

  // watchdog on total run length
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > RUN_LIMIT) begin
      $display("%0t: run limit reached", $realtime);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    stim_row_t   dir_tab[];
    result_t     ovf_res;
    sample_t     b;
    int unsigned drain;

    ovf_res = '0;
    ovf_res.overflow = 1'b1;

    // extremes are typed in, mixed sets go through the predictor
    dir_tab = '{
      '{'{32'h0000_0000, 1'b1}, 1'b1,
        '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 11'd1, 1'b0}},
      '{'{32'hFFFF_FFFF, 1'b1}, 1'b1,
        '{'1, '1, '1, '1, '1, '1, 11'd1, 1'b0}},
      '{'{32'hFFFF_FFFF, 1'b0}, 1'b0, '0},
      '{'{32'hFFFF_FFFF, 1'b1}, 1'b1,
        '{'1, '1, '1, '1, '1, '1, 11'd2, 1'b0}},
      '{'{32'h0000_0000, 1'b0}, 1'b0, '0},
      '{'{32'hFFFF_FFFF, 1'b1}, 1'b0, '0},
      '{'{32'd7, 1'b0}, 1'b0, '0},
      '{'{32'd3, 1'b0}, 1'b0, '0},
      '{'{32'd9, 1'b0}, 1'b0, '0},
      '{'{32'd1, 1'b0}, 1'b0, '0},
      '{'{32'd5, 1'b1}, 1'b0, '0},
      '{'{32'd40, 1'b0}, 1'b0, '0},
      '{'{32'd10, 1'b0}, 1'b0, '0},
      '{'{32'd31, 1'b0}, 1'b0, '0},
      '{'{32'd20, 1'b1}, 1'b0, '0},
      '{'{32'hAAAA_AAAA, 1'b0}, 1'b0, '0},
      '{'{32'h5555_5555, 1'b0}, 1'b0, '0},
      '{'{32'h5555_5555, 1'b1}, 1'b0, '0}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset percentiles
    foreach (dir_tab[i]) begin
      send_beat(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].want);
      push_gap();
    end
    push <= 1'b0;
    @(posedge clk_i);

    // a completely full store, then one sample past it
    send_set(SET_CAP);
    for (int unsigned i = 0; i <= SET_CAP; i++) begin
      b.sample_value = $urandom();
      b.is_last      = (i == SET_CAP);
      send_beat(b, b.is_last, ovf_res);
    end
    push <= 1'b0;

    // percentile extremes, including settings past 1000
    set_pms(32'd0, 32'd1000);
    send_set(1);
    send_set(2);
    send_set(7);
    set_pms(32'd1023, 32'd1);
    send_set(3);
    send_set(10);

    // random part over several percentile settings
    for (int unsigned phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_pms(32'd500, 32'd999);
        1: set_pms(32'($urandom_range(0, 1023)), 32'($urandom_range(0, 1023)));
        2: set_pms(32'd1000, 32'd0);
        default: set_pms(32'd950, 32'd990);
      endcase
      for (int unsigned s = 0; s < 22; s++) begin
        // one long result-side hold-off while sets keep coming
        if (phase == 1 && s == 4)
          long_hold = 1'b1;
        if ($urandom_range(0, 9) == 0)
          send_set($urandom_range(13, 40));
        else
          send_set($urandom_range(1, 12));
      end
    end

    // let every outstanding result drain, then idle a little more
    drain = 0;
    while (stats_due.size() != 0 && drain < DRAIN_CYC) begin
      @(posedge clk_i);
      drain++;
    end
    if (stats_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $realtime, stats_due.size());
      err_cnt++;
    end
    repeat (200) @(posedge clk_i);

    $display("covered %0d sample beats in %0d sets, %0d of them overflowed",
             beats_sent, sets_closed, ovf_sets);
    $display("percentile settings from 0 to 1023, full store and long result stall");
    if (err_cnt == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
